### rtl/circular_deque_defines.svh
// ----------------------------------------------------------------------------
// circular_deque assertion macros
// Simulation-only concurrent checks; empty bodies under synthesis.
// Users must have clock and reset in scope.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CDQ_ASSERT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("circular_deque: check failed");
// next-cycle implication
`define CDQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("circular_deque: check failed");
`else
`define CDQ_ASSERT(label, ante, cons)
`define CDQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared codes, widths and types of the circular deque.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

   localparam int DEFAULT_DEPTH = 8;
   localparam int DATA_W        = 32;
   localparam int OP_W          = 3;
   localparam int STATUS_W      = 2;

   // request codes
   localparam logic [OP_W-1:0] OP_PUSH_REAR = 3'd0;
   localparam logic [OP_W-1:0] OP_POP_FRONT = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_REAR  = 3'd2;
   localparam logic [OP_W-1:0] OP_PEEK      = 3'd3;
   localparam logic [OP_W-1:0] OP_DUMP      = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

   // index/occupancy update request
   typedef struct packed {
      logic push;
      logic pop_front;
      logic pop_rear;
   } ptr_cmd_type;

   // result control carried alongside the ram read
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                last;
      logic                use_data;
   } rsp_ctl_type;

endpackage

`default_nettype wire

### rtl/cdq_ram.sv
// ----------------------------------------------------------------------------
// cdq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/cdq_ptr.sv
// ----------------------------------------------------------------------------
// cdq_ptr
// Head and tail indices and occupancy of the ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "circular_deque_defines.svh"

module cdq_ptr #(
   parameter int DEPTH = cdq_pkg::DEFAULT_DEPTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cdq_pkg::ptr_cmd_type       cmd,
   output      logic [$clog2(DEPTH)-1:0]   head_index,
   output      logic [$clog2(DEPTH)-1:0]   tail_index,
   output      logic [$clog2(DEPTH+1)-1:0] occupancy,
   output      logic [$clog2(DEPTH)-1:0]   push_index
);
   import cdq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic [IDX_W-1:0] head_inc, tail_inc, tail_dec;
   logic             going_empty;
   logic [CNT_W:0]   tail_sum;
   logic [IDX_W-1:0] tail_expect;

   assign head_inc    = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign tail_inc    = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
   assign tail_dec    = (tail_ff == '0) ? LAST_IDX : tail_ff - 1'b1;
   assign going_empty = (occ_ff == CNT_W'(1));

   // push into an empty queue restarts at entry zero
   assign push_index = (occ_ff == '0) ? '0 : tail_inc;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      occ_in  = occ_ff;
      priority if (cmd.push) begin
         tail_in = push_index;
         if (occ_ff == '0) begin
            head_in = '0;
         end
         occ_in = occ_ff + 1'b1;
      end else if (cmd.pop_front || cmd.pop_rear) begin
         occ_in = occ_ff - 1'b1;
         if (going_empty) begin
            head_in = '0;
            tail_in = '0;
         end else if (cmd.pop_front) begin
            head_in = head_inc;
         end else begin
            tail_in = tail_dec;
         end
      end else begin
         occ_in = occ_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         occ_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff  <= occ_in;
      end
   end

   assign head_index = head_ff;
   assign tail_index = tail_ff;
   assign occupancy  = occ_ff;

   // expected rear position from front and count
   assign tail_sum    = (CNT_W+1)'(head_ff) + (CNT_W+1)'(occ_ff) - 1'b1;
   assign tail_expect = (tail_sum >= (CNT_W+1)'(DEPTH)) ?
                        IDX_W'(tail_sum - (CNT_W+1)'(DEPTH)) : IDX_W'(tail_sum);

   `CDQ_ASSERT(a_empty_idx_zero, occ_ff == '0, head_ff == '0 && tail_ff == '0)
   `CDQ_ASSERT(a_tail_consistent, occ_ff != '0, tail_ff == tail_expect)
   `CDQ_ASSERT(a_no_push_full, cmd.push, occ_ff != CNT_W'(DEPTH))

endmodule

`default_nettype wire

### rtl/circular_deque.sv
// Path: accepted request -> ram read stage -> output register -> rsp_valid.
// Throughput: push, pop and peek take one item per cycle while rsp_ready does not
//   stall the output; a dump holds req_ready low and streams one word per cycle,
//   set by the single ram read port, while the output is not stalled.
// Reset: synchronous; clears indices, occupancy and pipeline valids. Entry ram is
//   not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
// circular_deque
// Ring-buffer double-ended queue of signed 32-bit words with dump streaming.
// ----------------------------------------------------------------------------
`default_nettype none
`include "circular_deque_defines.svh"

module circular_deque #(
   parameter int DEPTH = cdq_pkg::DEFAULT_DEPTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_ready,
   input  wire logic        [cdq_pkg::OP_W-1:0]    req_op,
   input  wire logic signed [cdq_pkg::DATA_W-1:0]  req_value,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   output      logic        [cdq_pkg::STATUS_W-1:0] rsp_status,
   output      logic signed [cdq_pkg::DATA_W-1:0]  rsp_data,
   output      logic                               rsp_last
);
   import cdq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   // pointer state
   ptr_cmd_type      cmd;
   logic [IDX_W-1:0] head_index, tail_index, push_index;
   logic [CNT_W-1:0] occupancy;
   logic             empty, full;

   // ram ports
   logic              ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [DATA_W-1:0] ram_rd_data;

   // read stage: control for the word coming out of the ram
   logic        s1_valid_ff, s1_valid_in;
   rsp_ctl_type s1_ctl_ff, s1_ctl_in;
   logic        s1_move, slot_free;

   // dump sequencer
   logic             dump_busy_ff, dump_busy_in;
   logic [IDX_W-1:0] dump_idx_ff, dump_idx_in;
   logic [CNT_W-1:0] dump_rem_ff, dump_rem_in;
   logic             dump_step;
   logic [IDX_W-1:0] head_inc, dump_inc;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [DATA_W-1:0]   rsp_data_ff;
   logic                rsp_last_ff;

   logic accept, issue;

   assign empty = (occupancy == '0);
   assign full  = (occupancy == CNT_W'(DEPTH));

   // read stage advances when the output register is empty or draining
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign slot_free = !s1_valid_ff || s1_move;
   assign req_ready = slot_free && !dump_busy_ff;
   assign accept    = req_valid && req_ready;
   assign dump_step = dump_busy_ff && slot_free;

   assign head_inc = (head_index == LAST_IDX) ? '0 : head_index + 1'b1;
   assign dump_inc = (dump_idx_ff == LAST_IDX) ? '0 : dump_idx_ff + 1'b1;

   // request decode, dump stepping and ram read issue
   always_comb begin
      cmd          = '0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = head_index;
      issue        = 1'b0;
      s1_ctl_in    = s1_ctl_ff;
      dump_busy_in = dump_busy_ff;
      dump_idx_in  = dump_idx_ff;
      dump_rem_in  = dump_rem_ff;

      if (dump_step) begin
         issue              = 1'b1;
         ram_rd_en          = 1'b1;
         ram_rd_addr        = dump_idx_ff;
         s1_ctl_in.status   = ST_OK;
         s1_ctl_in.use_data = 1'b1;
         s1_ctl_in.last     = (dump_rem_ff == CNT_W'(1));
         dump_idx_in        = dump_inc;
         dump_rem_in        = dump_rem_ff - 1'b1;
         dump_busy_in       = (dump_rem_ff != CNT_W'(1));
      end else if (accept) begin
         s1_ctl_in.last     = 1'b1;
         s1_ctl_in.use_data = 1'b0;
         s1_ctl_in.status   = ST_OK;
         unique case (req_op)
            OP_PUSH_REAR: begin
               issue = 1'b1;
               if (full) begin
                  s1_ctl_in.status = ST_OVERFLOW;
               end else begin
                  cmd.push  = 1'b1;
                  ram_wr_en = 1'b1;
               end
            end
            OP_POP_FRONT, OP_POP_REAR, OP_PEEK: begin
               issue = 1'b1;
               if (empty) begin
                  s1_ctl_in.status = ST_UNDERFLOW;
               end else begin
                  ram_rd_en          = 1'b1;
                  s1_ctl_in.use_data = 1'b1;
                  ram_rd_addr        = (req_op == OP_POP_REAR) ? tail_index : head_index;
                  cmd.pop_front      = (req_op == OP_POP_FRONT);
                  cmd.pop_rear       = (req_op == OP_POP_REAR);
               end
            end
            OP_DUMP: begin
               issue = 1'b1;
               if (empty) begin
                  s1_ctl_in.status = ST_UNDERFLOW;
               end else begin
                  // first word goes out now, the rest through the sequencer
                  ram_rd_en          = 1'b1;
                  s1_ctl_in.use_data = 1'b1;
                  s1_ctl_in.last     = (occupancy == CNT_W'(1));
                  dump_busy_in       = (occupancy != CNT_W'(1));
                  dump_idx_in        = head_inc;
                  dump_rem_in        = occupancy - 1'b1;
               end
            end
            default: begin
               issue = 1'b0;   // unused codes: dropped silently
            end
         endcase
      end else begin
         issue = 1'b0;
      end
   end

   assign s1_valid_in  = issue ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_move ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dump_busy_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         dump_busy_ff <= dump_busy_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_ctl_ff   <= s1_ctl_in;
      dump_idx_ff <= dump_idx_in;
      dump_rem_ff <= dump_rem_in;
      if (s1_move) begin
         rsp_status_ff <= s1_ctl_ff.status;
         rsp_last_ff   <= s1_ctl_ff.last;
         rsp_data_ff   <= s1_ctl_ff.use_data ? ram_rd_data : '0;
      end
   end

   cdq_ptr #(
      .DEPTH (DEPTH)
   ) u_ptr (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .head_index (head_index),
      .tail_index (tail_index),
      .occupancy  (occupancy),
      .push_index (push_index)
   );

   // a push is written at the edge of its accept; any later read sees it
   cdq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (push_index),
      .wr_data (req_value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_last   = rsp_last_ff;

   // a word waiting in the read stage must not be overwritten by a new read
   `CDQ_ASSERT_NEXT(a_rd_hold, s1_valid_ff && !s1_move, $stable(ram_rd_data))
   // no state change while a dump is streaming
   `CDQ_ASSERT(a_dump_no_cmd, dump_busy_ff, cmd == '0 && !ram_wr_en)

endmodule

`default_nettype wire

### tb/tb_circular_deque.sv
// ----------------------------------------------------------------------------
// tb_circular_deque
// Self-checking bench for the circular deque. A short directed table covers
// empty, full, wrap-around, reserved codes and the extreme words. A random
// run follows, with fill and drain bias, under four idling phases. Every
// accepted request goes through a local copy of the deque, and each result
// item is checked field by field against the oldest expected one.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_circular_deque;

   timeunit 1ns;
   timeprecision 1ps;

   import cdq_pkg::*;

   localparam int DEPTH       = DEFAULT_DEPTH;
   localparam int ITEMS_PHASE = 26;      // random items per idling phase
   localparam int TAIL_CYCLES = 8;
   localparam int RUN_LIMIT   = 2000000; // ns, far beyond the slowest run

   // Reserved request codes: the block must swallow these silently.
   localparam logic [OP_W-1:0] OP_RSVD_A = 3'd5;
   localparam logic [OP_W-1:0] OP_RSVD_B = 3'd6;
   localparam logic [OP_W-1:0] OP_RSVD_C = 3'd7;

   typedef struct {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] data;
      logic                     last;
   } deque_rsp_type;

   // One row of the directed table. When fixed is set, the single result
   // is typed in here instead of being taken from the local deque.
   typedef struct {
      logic [OP_W-1:0]          op;
      logic signed [DATA_W-1:0] value;
      bit                       fixed;
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] data;
   } stim_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [OP_W-1:0]           req_op = OP_PUSH_REAR;
   logic signed [DATA_W-1:0]  req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [STATUS_W-1:0]       rsp_status;
   logic signed [DATA_W-1:0]  rsp_data;
   logic                      rsp_last;

   // Local copy of the deque.
   logic signed [DATA_W-1:0]  ring_words [DEPTH];
   int unsigned               front_idx;
   int unsigned               rear_idx;
   int unsigned               word_count;

   deque_rsp_type             pending_rsps [$];  // results still owed by the block
   deque_rsp_type             step_rsps [$];     // results of the latest request
   stim_row_type              directed_rows [$];

   // Side info travelling with the item on the request port.
   bit                        cur_fixed = 1'b0;
   logic [STATUS_W-1:0]       cur_status = ST_OK;
   logic signed [DATA_W-1:0]  cur_data = '0;

   int                        send_idle_pct = 0;
   int                        rsp_stall_pct = 0;
   int                        failures = 0;

   circular_deque #(
      .DEPTH (DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_op     (req_op),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status),
      .rsp_data   (rsp_data),
      .rsp_last   (rsp_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Local deque: applies one request and leaves its results in step_rsps.
   // ------------------------------------------------------------------------
   task automatic deque_reset();
      for (int i = 0; i < DEPTH; i++) ring_words[i] = '0;
      front_idx  = 0;
      rear_idx   = 0;
      word_count = 0;
   endtask

   task automatic deque_apply(input logic [OP_W-1:0] op,
                              input logic signed [DATA_W-1:0] value);
      deque_rsp_type r;
      int unsigned   idx;
      step_rsps.delete();
      r.status = ST_OK;
      r.data   = '0;
      r.last   = 1'b1;
      if (op == OP_PUSH_REAR) begin
         if (word_count >= DEPTH) begin
            r.status = ST_OVERFLOW;
         end else begin
            // first word after empty always lands in slot zero
            if (word_count == 0) begin
               front_idx = 0;
               rear_idx  = 0;
            end else begin
               rear_idx = (rear_idx + 1) % DEPTH;
            end
            ring_words[rear_idx] = value;
            word_count++;
         end
         step_rsps.push_back(r);
      end else if (op == OP_POP_FRONT || op == OP_POP_REAR || op == OP_PEEK ||
                   op == OP_DUMP) begin
         if (word_count == 0) begin
            r.status = ST_UNDERFLOW;
            step_rsps.push_back(r);
         end else if (op == OP_DUMP) begin
            // front to rear, last only on the rear word; state untouched
            idx = front_idx;
            for (int n = 0; n < word_count; n++) begin
               r.data = ring_words[idx];
               r.last = (n + 1 == word_count);
               step_rsps.push_back(r);
               idx = (idx + 1) % DEPTH;
            end
         end else if (op == OP_PEEK) begin
            r.data = ring_words[front_idx];
            step_rsps.push_back(r);
         end else begin
            r.data = (op == OP_POP_FRONT) ? ring_words[front_idx] : ring_words[rear_idx];
            word_count--;
            if (word_count == 0) begin
               front_idx = 0;
               rear_idx  = 0;
            end else if (op == OP_POP_FRONT) begin
               front_idx = (front_idx + 1) % DEPTH;
            end else begin
               rear_idx = (rear_idx + DEPTH - 1) % DEPTH;
            end
            step_rsps.push_back(r);
         end
      end
      // reserved codes: no result, no change
   endtask

   // ------------------------------------------------------------------------
   // Monitor: both channels sampled at the rising edge.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      deque_rsp_type want;
      deque_rsp_type typed;
      if (!reset) begin
         if (req_valid && req_ready) begin
            deque_apply(req_op, req_value);
            if (cur_fixed) begin
               typed.status = cur_status;
               typed.data   = cur_data;
               typed.last   = 1'b1;
               pending_rsps.push_back(typed);
            end else begin
               foreach (step_rsps[i]) pending_rsps.push_back(step_rsps[i]);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_rsps.size() == 0) begin
               $display("%0t: unexpected result item status %0d data %0d last %0b",
                        $time, rsp_status, rsp_data, rsp_last);
               failures++;
            end else begin
               want = pending_rsps.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d actual %0d",
                           $time, want.status, rsp_status);
                  failures++;
               end
               if (rsp_data !== want.data) begin
                  $display("%0t: data mismatch, expected %0d actual %0d",
                           $time, want.data, rsp_data);
                  failures++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last mismatch, expected %0b actual %0b",
                           $time, want.last, rsp_last);
                  failures++;
               end
            end
         end
      end
   end

   // Receiver back-pressure, changed on the falling edge.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // ------------------------------------------------------------------------
   // Sender: entered and left at a falling edge. Random gaps come first,
   // then the item is held until the port takes it.
   // ------------------------------------------------------------------------
   task automatic send_item(input logic [OP_W-1:0] op,
                            input logic signed [DATA_W-1:0] value,
                            input bit fixed,
                            input logic [STATUS_W-1:0] status,
                            input logic signed [DATA_W-1:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_op     = op;
      req_value  = value;
      cur_fixed  = fixed;
      cur_status = status;
      cur_data   = data;
      req_valid  = 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
   endtask

   task automatic add_row(input logic [OP_W-1:0] op,
                          input logic signed [DATA_W-1:0] value,
                          input bit fixed,
                          input logic [STATUS_W-1:0] status,
                          input logic signed [DATA_W-1:0] data);
      stim_row_type row;
      row.op     = op;
      row.value  = value;
      row.fixed  = fixed;
      row.status = status;
      row.data   = data;
      directed_rows.push_back(row);
   endtask

   // Random request, biased toward push by push_pct so the queue fills and
   // drains often enough to hit both full and empty.
   function automatic logic [OP_W-1:0] pick_op(input int push_pct);
      int r;
      r = $urandom_range(99);
      if (r < push_pct) return OP_PUSH_REAR;
      r = $urandom_range(99);
      if (r < 30) return OP_POP_FRONT;
      if (r < 55) return OP_POP_REAR;
      if (r < 70) return OP_PEEK;
      if (r < 92) return OP_DUMP;
      case ($urandom_range(2))
         0:       return OP_RSVD_A;
         1:       return OP_RSVD_B;
         default: return OP_RSVD_C;
      endcase
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(7))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   task automatic wait_drained();
      while (pending_rsps.size() != 0) @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      int push_pct;
      deque_reset();

      // empty queue: every read answers underflow
      add_row(OP_POP_FRONT, '0,             1, ST_UNDERFLOW, '0);
      add_row(OP_POP_REAR,  32'sh1234_5678, 1, ST_UNDERFLOW, '0);
      add_row(OP_PEEK,      '0,             1, ST_UNDERFLOW, '0);
      add_row(OP_DUMP,      '0,             1, ST_UNDERFLOW, '0);
      // reserved codes give nothing
      add_row(OP_RSVD_A,    32'sh7FFF_FFFF, 0, ST_OK, '0);
      add_row(OP_RSVD_C,    -32'sd1,        0, ST_OK, '0);
      // single word in, peeked, taken from the rear: back to empty
      add_row(OP_PUSH_REAR, 32'sh7FFF_FFFF, 1, ST_OK, '0);
      add_row(OP_PEEK,      '0,             1, ST_OK, 32'sh7FFF_FFFF);
      add_row(OP_POP_REAR,  '0,             1, ST_OK, 32'sh7FFF_FFFF);
      // fill to capacity with extreme and alternating patterns
      add_row(OP_PUSH_REAR, 32'sh8000_0000, 1, ST_OK, '0);
      add_row(OP_PUSH_REAR, '0,             1, ST_OK, '0);
      add_row(OP_PUSH_REAR, -32'sd1,        1, ST_OK, '0);
      add_row(OP_PUSH_REAR, 32'sd1,         1, ST_OK, '0);
      add_row(OP_PUSH_REAR, 32'sh5555_5555, 1, ST_OK, '0);
      add_row(OP_PUSH_REAR, 32'shAAAA_AAAA, 1, ST_OK, '0);
      add_row(OP_PUSH_REAR, 32'sh1234_5678, 1, ST_OK, '0);
      add_row(OP_PUSH_REAR, 32'shDEAD_BEEF, 1, ST_OK, '0);
      // full: push refused
      add_row(OP_PUSH_REAR, 32'sh0BAD_F00D, 1, ST_OVERFLOW, '0);
      add_row(OP_DUMP,      '0,             0, ST_OK, '0);
      add_row(OP_POP_FRONT, '0,             1, ST_OK, 32'sh8000_0000);
      // tail wraps past the end of the ring
      add_row(OP_PUSH_REAR, 32'sd6,         0, ST_OK, '0);
      add_row(OP_DUMP,      '0,             0, ST_OK, '0);
      add_row(OP_POP_REAR,  '0,             0, ST_OK, '0);
      add_row(OP_RSVD_B,    32'sh5555_AAAA, 0, ST_OK, '0);
      add_row(OP_DUMP,      '0,             0, ST_OK, '0);

      // synchronous reset, then released on a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].op, directed_rows[i].value, directed_rows[i].fixed,
                   directed_rows[i].status, directed_rows[i].data);
      end

      // Random part: four idling phases. Each phase starts only once every
      // owed result has come back, so the sender pauses at least that long.
      for (int phase = 0; phase < 4; phase++) begin
         req_valid = 1'b0;
         wait_drained();
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 73; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 73; end
            default: begin send_idle_pct = 11; rsp_stall_pct = 11; end
         endcase
         push_pct = 50;
         for (int n = 0; n < ITEMS_PHASE; n++) begin
            // swing between fill, balance and drain every few items
            if (n % 8 == 0) begin
               case ($urandom_range(2))
                  0:       push_pct = 85;
                  1:       push_pct = 50;
                  default: push_pct = 20;
               endcase
            end
            send_item(pick_op(push_pct), pick_value(), 0, ST_OK, '0);
         end
      end

      req_valid = 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      wait_drained();
      // wait on to catch any stray result item
      repeat (TAIL_CYCLES) @(negedge clock);
      if (failures == 0 && pending_rsps.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(RUN_LIMIT);
      $display("%0t: timeout, %0d result items still owed", $time, pending_rsps.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire

### files.f
+incdir+rtl
rtl/cdq_pkg.sv
rtl/cdq_ram.sv
rtl/cdq_ptr.sv
rtl/circular_deque.sv
tb/tb_circular_deque.sv
